### rtl/core/dhv_pkg.sv
// ----------------------------------------------------------------------------
// dhv_pkg
// Shared types and constants for the DNA hit verifier: register indexes,
// request codes, field widths and the configuration register set.
// ----------------------------------------------------------------------------
package dhv_pkg;

  localparam int BASES_PER_WORD = 32;
  localparam int BASE_W         = 2;
  localparam int WORD_W         = BASES_PER_WORD * BASE_W;
  localparam int POS_W          = 32;
  localparam int OFF_W          = 5;
  localparam int LEN_W          = 6;
  localparam int CNT_W          = 9;
  localparam int IDX_W          = 8;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 64;

  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    REG_QUERY_PATTERN  = 3'd0,
    REG_QUERY_LENGTH   = 3'd1,
    REG_WILD_MASK      = 3'd2,
    REG_MM_LIMIT       = 3'd3,
    REG_STRAND_MINUS   = 3'd4,
    REG_GENOME_BLOCKS  = 3'd5,
    REG_CHROM_COUNT    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0]         query_pattern;
    logic [LEN_W-1:0]          query_length;
    logic [BASES_PER_WORD-1:0] wild_mask;
    logic [LEN_W-1:0]          mm_limit;
    logic                      strand_minus;
    logic [POS_W-1:0]          genome_blocks;
    logic [CNT_W-1:0]          chrom_count;
  } cfg_t;

endpackage

### rtl/core/dhv_ram.sv
// ----------------------------------------------------------------------------
// dhv_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module dhv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/dna_hit_verify.sv
// ----------------------------------------------------------------------------
// dna_hit_verify
// Verifies candidate hits against a 2-bit genome and maps them to chromosomes.
//
// Input words are taken when start is high and busy is low. A load word
// (req_type 1) writes one chromosome start entry in its accept cycle. A check
// word is screened for genome bounds and window overrun in its accept cycle,
// then its mismatch count is formed, then a binary search of S steps runs over
// the chromosome start RAM, one registered RAM read per step.
// Load words and screened-out words leave busy low. A mismatch or empty-table
// drop ends busy after the count state; other check words also take the S
// search steps, S at most ceil(log2(n + 1)) with n the chrom_count capped at
// the depth, then, for a hit, a final start read. A passing hit drives
// out_valid for exactly one cycle, the first cycle with busy low again; the
// receiver cannot stall it. One word is in flight; none is taken while busy.
// Configuration writes on cfg_ take effect on the next cycle; make them idle.
// Reset (rst_n low, synchronous) clears the FSM, out_valid and cfg_r, with
// query_length 20. The start table is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module dna_hit_verify #(
  parameter int CHROM_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dhv_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [dhv_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [dhv_pkg::POS_W-1:0]          in_position,
  input  logic [dhv_pkg::WORD_W-1:0]         in_block_word,
  input  logic [dhv_pkg::WORD_W-1:0]         in_next_word,
  input  logic                               in_next_present,
  input  logic [dhv_pkg::IDX_W-1:0]          in_entry_index,
  input  logic [dhv_pkg::POS_W-1:0]          in_entry_start,
  output logic                               out_valid,
  output logic [dhv_pkg::IDX_W-1:0]          out_chrom_id,
  output logic [dhv_pkg::POS_W-1:0]          out_rel_position,
  output logic [dhv_pkg::WORD_W-1:0]         out_window_bases,
  output logic [dhv_pkg::LEN_W-1:0]          out_mismatch_count,
  output logic                               out_strand_tag
);

  import dhv_pkg::*;

  localparam int AW = (CHROM_DEPTH > 1) ? $clog2(CHROM_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_CMP,
    ST_FINAL
  } state_t;

  function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] v);
    logic [AW+CNT_W-1:0] w;
    w = {{AW{1'b0}}, v};
    return w[AW-1:0];
  endfunction

  cfg_t                      cfg_r;
  state_t                    state_r, state_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [WORD_W-1:0]         win_r, win_nxt;
  logic [BASES_PER_WORD-1:0] diff_r, diff_nxt;
  logic [LEN_W-1:0]          mm_r, mm_nxt;
  logic [CNT_W-1:0]          lo_r, lo_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [CNT_W-1:0]          mid_r, mid_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_chrom_id_r;
  logic [POS_W-1:0]          out_rel_position_r;
  logic [WORD_W-1:0]         out_window_bases_r;
  logic [LEN_W-1:0]          out_mismatch_count_r;
  logic                      out_strand_tag_r;

  logic                      accept;
  logic [POS_W-1:0]          widx;
  logic [LEN_W-1:0]          len;
  logic [OFF_W-1:0]          off;
  logic                      two_words;
  logic [LEN_W:0]            need;
  logic                      chk_drop;
  logic [2*WORD_W-1:0]       pair_shift;
  logic [WORD_W-1:0]         win_raw;
  logic [WORD_W-1:0]         win_mask;
  logic [BASES_PER_WORD-1:0] diff_comb;
  logic [2:0]                grp_sum [BASES_PER_WORD/4];
  logic [LEN_W-1:0]          mm_comb;
  logic [CNT_W-1:0]          count_sat;
  logic [CNT_W-1:0]          cmp_lo, cmp_n;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [POS_W-1:0]          ram_rdata;

  dhv_ram #(
    .WIDTH (POS_W),
    .DEPTH (CHROM_DEPTH)
  ) u_starts (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_entry_start),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign ram_we    = accept && (in_req_type == REQ_LOAD) &&
                     (32'(in_entry_index) < CHROM_DEPTH);
  assign ram_waddr = to_addr({1'b0, in_entry_index});

  // screen a check word against genome bounds and build its window
  always_comb begin
    widx       = {5'd0, in_position[POS_W-1:OFF_W]};
    off        = in_position[OFF_W-1:0];
    len        = (cfg_r.query_length > 6'd32) ? 6'd32 : cfg_r.query_length;
    two_words  = in_next_present && ((widx + 32'd1) < cfg_r.genome_blocks);
    need       = {2'b00, off} + {1'b0, len};
    chk_drop   = (widx >= cfg_r.genome_blocks) ||
                 (need > (two_words ? 7'd64 : 7'd32));
    pair_shift = {in_next_word, in_block_word} >> {off, 1'b0};
    win_raw    = pair_shift[WORD_W-1:0];
    for (int k = 0; k < BASES_PER_WORD; k++) begin
      win_mask[2*k +: 2] = (6'(k) < len) ? 2'b11 : 2'b00;
      diff_comb[k] = (6'(k) < len) &&
                     (cfg_r.wild_mask[k] ||
                      (win_raw[2*k +: 2] != cfg_r.query_pattern[2*k +: 2]));
    end
  end

  // two-level popcount of the registered mismatch vector
  always_comb begin
    for (int g = 0; g < BASES_PER_WORD/4; g++) begin
      grp_sum[g] = 3'(diff_r[4*g]) + 3'(diff_r[4*g+1]) +
                   3'(diff_r[4*g+2]) + 3'(diff_r[4*g+3]);
    end
    mm_comb = '0;
    for (int g = 0; g < BASES_PER_WORD/4; g++) begin
      mm_comb = mm_comb + 6'(grp_sum[g]);
    end
  end

  always_comb begin
    count_sat = (32'(cfg_r.chrom_count) > CHROM_DEPTH) ? CNT_W'(CHROM_DEPTH)
                                                       : cfg_r.chrom_count;
    if (ram_rdata > pos_r) begin
      cmp_lo = lo_r;
      cmp_n  = n_r >> 1;
    end else begin
      cmp_lo = mid_r + 9'd1;
      cmp_n  = n_r - (n_r >> 1) - 9'd1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    win_nxt       = win_r;
    diff_nxt      = diff_r;
    mm_nxt        = mm_r;
    lo_nxt        = lo_r;
    n_nxt         = n_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = to_addr(mid_r);
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_CHECK) && !chk_drop) begin
          pos_nxt   = in_position;
          win_nxt   = win_raw & win_mask;
          diff_nxt  = diff_comb;
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        mm_nxt = mm_comb;
        lo_nxt = '0;
        n_nxt  = count_sat;
        if ((mm_comb > cfg_r.mm_limit) || (count_sat == '0)) begin
          state_nxt = ST_IDLE;
        end else begin
          mid_nxt   = count_sat >> 1;
          ram_re    = 1'b1;
          ram_raddr = to_addr(count_sat >> 1);
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        lo_nxt = cmp_lo;
        n_nxt  = cmp_n;
        if (cmp_n == '0) begin
          if (cmp_lo == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            mid_nxt   = cmp_lo - 9'd1;
            ram_re    = 1'b1;
            ram_raddr = to_addr(cmp_lo - 9'd1);
            state_nxt = ST_FINAL;
          end
        end else begin
          mid_nxt   = cmp_lo + (cmp_n >> 1);
          ram_re    = 1'b1;
          ram_raddr = to_addr(cmp_lo + (cmp_n >> 1));
        end
      end
      ST_FINAL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= '{query_length: 6'd20, default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_QUERY_PATTERN:  cfg_r.query_pattern  <= cfg_wdata;
          REG_QUERY_LENGTH:   cfg_r.query_length   <= cfg_wdata[LEN_W-1:0];
          REG_WILD_MASK:      cfg_r.wild_mask      <= cfg_wdata[BASES_PER_WORD-1:0];
          REG_MM_LIMIT:       cfg_r.mm_limit       <= cfg_wdata[LEN_W-1:0];
          REG_STRAND_MINUS:   cfg_r.strand_minus   <= cfg_wdata[0];
          REG_GENOME_BLOCKS:  cfg_r.genome_blocks  <= cfg_wdata[POS_W-1:0];
          REG_CHROM_COUNT:    cfg_r.chrom_count    <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pos_r  <= pos_nxt;
    win_r  <= win_nxt;
    diff_r <= diff_nxt;
    mm_r   <= mm_nxt;
    lo_r   <= lo_nxt;
    n_r    <= n_nxt;
    mid_r  <= mid_nxt;
    if (state_r == ST_FINAL) begin
      out_chrom_id_r       <= mid_r[IDX_W-1:0];
      out_rel_position_r   <= pos_r - ram_rdata;
      out_window_bases_r   <= win_r;
      out_mismatch_count_r <= mm_r;
      out_strand_tag_r     <= cfg_r.strand_minus;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chrom_id       = out_chrom_id_r;
  assign out_rel_position   = out_rel_position_r;
  assign out_window_bases   = out_window_bases_r;
  assign out_mismatch_count = out_mismatch_count_r;
  assign out_strand_tag     = out_strand_tag_r;

endmodule
